### hw/rtl/sdd_pkg.sv
package sdd_pkg;

  // Door travel in half steps, closed reference at zero
  localparam int unsigned FULL_STEPS_INT = 1024;
  localparam logic [15:0] FULL_STEPS     = 16'(FULL_STEPS_INT);

  // Forced-close watchdog limits
  localparam logic [15:0] TEST_MIN_LIMIT    = 16'd600;
  localparam logic [4:0]  TEST_PERIOD_LIMIT = 5'd5;
  localparam logic [15:0] NORM_MIN_LIMIT    = 16'd36000;
  localparam logic [4:0]  NORM_PERIOD_LIMIT = 5'd24;
  localparam logic [6:0]  GUARD_RELOAD      = 7'd70;

  // Register map
  localparam logic REG_TEST_MODE = 1'b0;

  // Item kinds carried in tuser
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_TIMER = 1'b1;

  typedef struct packed {
    logic [15:0] step_position;
    logic        open_request;
    logic        was_opening;
    logic [3:0]  coil_drive;
    logic [15:0] minute_ticks;
    logic [4:0]  period_count;
    logic [6:0]  guard_ticks;
  } state_t;

  typedef struct packed {
    logic kind;
    logic ice_dispensing;
    logic close_hold;
    logic open_set;
    logic open_clear;
  } item_t;

  // Half-step coil pattern, indexed by position mod 8
  function automatic logic [3:0] phase_coils(input logic [2:0] phase);
    logic [3:0] c;
    unique case (phase)
      3'd0: c = 4'h1;
      3'd1: c = 4'h9;
      3'd2: c = 4'h8;
      3'd3: c = 4'hC;
      3'd4: c = 4'h4;
      3'd5: c = 4'h6;
      3'd6: c = 4'h2;
      3'd7: c = 4'h3;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/sdd_step.sv
// Next-state logic for one item: either a motor step or a watchdog tick.
module sdd_step (
  input  sdd_pkg::state_t state,
  input  sdd_pkg::item_t  item,
  input  logic            test_mode,
  output sdd_pkg::state_t state_nxt,
  output logic            forced
);

  logic        req;
  logic [15:0] min_limit;
  logic [4:0]  per_limit;
  logic [15:0] mt_base;
  logic [4:0]  pc_base;
  logic [15:0] mt_inc;
  logic [15:0] mt_wrap;
  logic [4:0]  pc_wrap;
  logic        force_now;
  logic [6:0]  guard_arm;
  logic [15:0] pos_base;
  logic [15:0] pos_mv;

  // Set first, clear second: clear wins
  assign req = (state.open_request | item.open_set) & ~item.open_clear;

  // Watchdog path
  assign min_limit = test_mode ? sdd_pkg::TEST_MIN_LIMIT    : sdd_pkg::NORM_MIN_LIMIT;
  assign per_limit = test_mode ? sdd_pkg::TEST_PERIOD_LIMIT : sdd_pkg::NORM_PERIOD_LIMIT;
  assign mt_base   = item.ice_dispensing ? 16'd0 : state.minute_ticks;
  assign pc_base   = item.ice_dispensing ? 5'd0  : state.period_count;
  assign mt_inc    = mt_base + 16'd1;

  always_comb begin
    if (mt_inc >= min_limit) begin
      mt_wrap = 16'd0;
      pc_wrap = pc_base + 5'd1;
    end else begin
      mt_wrap = mt_inc;
      pc_wrap = pc_base;
    end
  end

  assign force_now = (pc_wrap >= per_limit);
  assign guard_arm = force_now ? sdd_pkg::GUARD_RELOAD : state.guard_ticks;

  // Motor path: reload to full travel on the first closing step after opening
  assign pos_base = (!req && state.was_opening) ? sdd_pkg::FULL_STEPS : state.step_position;

  always_comb begin
    pos_mv = pos_base;
    if (req) begin
      if (pos_base < sdd_pkg::FULL_STEPS) pos_mv = pos_base + 16'd1;
      else                                pos_mv = sdd_pkg::FULL_STEPS;
    end else if (pos_base != 16'd0 && !item.close_hold) begin
      pos_mv = pos_base - 16'd1;
    end
  end

  always_comb begin
    state_nxt              = state;
    state_nxt.open_request = req;
    forced                 = 1'b0;
    unique case (item.kind)
      sdd_pkg::KIND_TIMER: begin
        forced                 = force_now;
        state_nxt.minute_ticks = force_now ? 16'd0 : mt_wrap;
        state_nxt.period_count = force_now ? 5'd0  : pc_wrap;
        state_nxt.guard_ticks  = (guard_arm != 7'd0) ? guard_arm - 7'd1 : 7'd0;
        if (force_now) state_nxt.step_position = sdd_pkg::FULL_STEPS;
      end
      sdd_pkg::KIND_STEP: begin
        state_nxt.step_position = pos_mv;
        state_nxt.was_opening   = req;
        // Drop the request at full travel unless ice is still running
        if (req && pos_base >= sdd_pkg::FULL_STEPS && !item.ice_dispensing)
          state_nxt.open_request = 1'b0;
        if (pos_mv == 16'd0 || pos_mv == sdd_pkg::FULL_STEPS)
          state_nxt.coil_drive = 4'h0;
        else
          state_nxt.coil_drive = sdd_pkg::phase_coils(pos_mv[2:0]);
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/stepper_door_driver_with_forced_close.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    tdata: ice, hold, open_set, open_clear; tuser: kind
// out_      out  out_tvalid/out_tready  tdata: coils, position, open_pending, forced, guard
// cfg_      in   APB, pready tied high  register 0 at byte 0: test_mode
//
// One item per cycle while out_tready stays high: the next-state logic runs from
// the state registers back to them in a single pass, and the state updates at accept.
// out_tvalid rises in the cycle after an accept.
// rst_n is synchronous, active low; it clears the door state, out_tvalid and test_mode.
// A stalled result holds in the result register; input is still taken in the
// same cycle the pending result is taken, so a full-rate stream sees no bubble.
module stepper_door_driver_with_forced_close (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] ice_dispensing, [1] close_hold, [2] open_set,
                                  // [3] open_clear, [7:4] zero
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] coils, [19:4] position, [20] open_pending,
                                  // [21] forced_close, [28:22] guard_count, [31:29] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  sdd_pkg::state_t state_r;
  sdd_pkg::state_t state_nxt;
  sdd_pkg::item_t  item;
  logic            forced;
  logic            test_mode_r;
  logic            out_valid_r;
  logic            out_forced_r;
  logic            in_accept;
  logic            cfg_write;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == sdd_pkg::REG_TEST_MODE) ? {31'd0, test_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mode_r <= 1'b0;
    end else if (cfg_write && cfg_paddr[2] == sdd_pkg::REG_TEST_MODE) begin
      test_mode_r <= cfg_pwdata[0];
    end
  end

  // Unpack the incoming item
  assign item.kind           = in_tuser;
  assign item.ice_dispensing = in_tdata[0];
  assign item.close_hold     = in_tdata[1];
  assign item.open_set       = in_tdata[2];
  assign item.open_clear     = in_tdata[3];

  // Take a new item whenever the result slot frees up this cycle
  assign in_tready = ~out_valid_r | out_tready;
  assign in_accept = in_tvalid & in_tready;

  sdd_step u_step (
    .state     (state_r),
    .item      (item),
    .test_mode (test_mode_r),
    .state_nxt (state_nxt),
    .forced    (forced)
  );

  // Advance state on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register: drop valid when taken, load on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_forced_r <= forced;
    end
  end

  // Result fields mirror the state that the last item left
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, state_r.guard_ticks, out_forced_r, state_r.open_request,
                       state_r.step_position, state_r.coil_drive};

  // A forced close lands at full travel with the guard window one tick in
  a_forced_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_forced_r |->
      state_r.step_position == sdd_pkg::FULL_STEPS &&
      state_r.guard_ticks == sdd_pkg::GUARD_RELOAD - 7'd1)
    else $error("forced close result without full position and armed guard");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.step_position <= sdd_pkg::FULL_STEPS)
    else $error("position beyond full travel");

  a_guard_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.guard_ticks < sdd_pkg::GUARD_RELOAD)
    else $error("guard count not decremented after arming");

  a_closed_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.step_position == 16'd0 |-> state_r.coil_drive == 4'h0)
    else $error("coils driven at closed reference");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(state_r))
    else $error("state changed without an accepted item");

endmodule
